// ----- rtl/spiram_pkg.sv -----
// Shared types and constants for the SPI register access master.
package spiram_pkg;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [7:0] WRITE_FLAG  = 8'h80;
  localparam logic [1:0] CS_IDLE     = 2'b11;
  localparam logic [1:0] CS_MODULE0  = 2'b10;
  localparam logic [1:0] CS_MODULE1  = 2'b01;
  localparam logic [2:0] LAST_BIT    = 3'd7;

  localparam logic REG_DEVICE_SELECT = 1'b0;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_WRITE,
    CMD_READ
  } cmd_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [6:0] address;
    logic [7:0] length;
    logic [7:0] write_data;
    logic       miso;
  } in_word_t;

  typedef struct packed {
    logic [1:0] chip_select_n;
    logic       sck;
    logic       mosi;
    logic [7:0] read_data;
    logic       read_valid;
    logic       data_request;
    logic       busy_res;
    logic       last_byte;
  } out_word_t;

  typedef struct packed {
    cmd_e       cmd;
    logic [6:0] address;
    logic [7:0] length;
    logic [7:0] write_data;
    logic       miso;
  } cmd_word_t;

endpackage

// ----- rtl/spiram_front.sv -----
// Front end: classifies each incoming word into a tick or a start command.
module spiram_front (
  input  spiram_pkg::in_word_t  word_i,
  output spiram_pkg::cmd_word_t cmd_o
);
  import spiram_pkg::*;

  cmd_e cmd;

  always_comb begin
    cmd = CMD_TICK;
    if (word_i.length != 8'd0) begin
      unique case (word_i.operation)
        OP_WRITE: cmd = CMD_WRITE;
        OP_READ:  cmd = CMD_READ;
        default:  cmd = CMD_TICK;
      endcase
    end
  end

  assign cmd_o.cmd        = cmd;
  assign cmd_o.address    = word_i.address;
  assign cmd_o.length     = word_i.length;
  assign cmd_o.write_data = word_i.write_data;
  assign cmd_o.miso       = word_i.miso;

endmodule

// ----- rtl/spiram_fifo.sv -----
// Small command queue between front end and engine.
module spiram_fifo #(
  parameter int Depth = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  spiram_pkg::cmd_word_t push_word_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output spiram_pkg::cmd_word_t head_o
);
  import spiram_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_word_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

endmodule

// ----- rtl/spiram_engine.sv -----
// Back end: SPI mode-0 shift engine with registered result word.
module spiram_engine (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  device_select_i,
  input  logic                  cmd_valid_i,
  input  spiram_pkg::cmd_word_t cmd_i,
  output logic                  cmd_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output spiram_pkg::out_word_t out_word_o
);
  import spiram_pkg::*;

  logic [7:0] shift_q, shift_d;
  logic [2:0] bit_count_q, bit_count_d;
  logic       phase_high_q, phase_high_d;
  logic [7:0] bytes_left_q, bytes_left_d;
  logic       is_read_q, is_read_d;
  logic       in_addr_q, in_addr_d;
  logic       active_q, active_d;
  logic       out_valid_q;
  out_word_t  out_word_q, out_word_d;
  logic       pop;
  logic       rvalid, dreq, last;
  logic [7:0] rdata;

  assign pop       = cmd_valid_i && (!out_valid_q || !out_stall_i);
  assign cmd_pop_o = pop;

  always_comb begin
    shift_d      = shift_q;
    bit_count_d  = bit_count_q;
    phase_high_d = phase_high_q;
    bytes_left_d = bytes_left_q;
    is_read_d    = is_read_q;
    in_addr_d    = in_addr_q;
    active_d     = active_q;
    rvalid       = 1'b0;
    rdata        = 8'h00;
    dreq         = 1'b0;
    last         = 1'b0;
    if (!active_q) begin
      if (cmd_i.cmd != CMD_TICK) begin
        active_d     = 1'b1;
        is_read_d    = (cmd_i.cmd == CMD_READ);
        shift_d      = {1'b0, cmd_i.address} | ((cmd_i.cmd == CMD_READ) ? 8'h00 : WRITE_FLAG);
        bit_count_d  = 3'd0;
        phase_high_d = 1'b0;
        bytes_left_d = cmd_i.length;
        in_addr_d    = 1'b1;
      end
    end else if (!phase_high_q) begin
      phase_high_d = 1'b1;
      if (is_read_q && !in_addr_q) begin
        shift_d = {shift_q[6:0], cmd_i.miso};
      end
      if (!is_read_q && bit_count_q == LAST_BIT && (in_addr_q || bytes_left_q > 8'd1)) begin
        dreq = 1'b1;
        last = in_addr_q ? (bytes_left_q == 8'd1) : (bytes_left_q == 8'd2);
      end
    end else begin
      phase_high_d = 1'b0;
      if (!(is_read_q && !in_addr_q)) begin
        shift_d = {shift_q[6:0], 1'b0};
      end
      bit_count_d = bit_count_q + 3'd1;
      if (bit_count_q == LAST_BIT) begin
        if (!in_addr_q) begin
          bytes_left_d = bytes_left_q - 8'd1;
          if (is_read_q) begin
            rvalid = 1'b1;
            rdata  = shift_q;
            last   = (bytes_left_d == 8'd0);
          end
        end
        in_addr_d = 1'b0;
        if (bytes_left_d == 8'd0) begin
          active_d  = 1'b0;
          is_read_d = 1'b0;
        end else begin
          shift_d = is_read_q ? 8'h00 : cmd_i.write_data;
        end
      end
    end
  end

  always_comb begin
    out_word_d.chip_select_n = CS_IDLE;
    out_word_d.sck           = 1'b0;
    out_word_d.mosi          = 1'b1;
    if (active_d) begin
      out_word_d.chip_select_n = device_select_i ? CS_MODULE1 : CS_MODULE0;
      out_word_d.sck           = phase_high_d;
      if (!(is_read_d && !in_addr_d)) begin
        out_word_d.mosi = shift_d[7];
      end
    end
    out_word_d.read_data    = rdata;
    out_word_d.read_valid   = rvalid;
    out_word_d.data_request = dreq;
    out_word_d.busy_res     = active_d;
    out_word_d.last_byte    = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q      <= 8'h00;
      bit_count_q  <= 3'd0;
      phase_high_q <= 1'b0;
      bytes_left_q <= 8'd0;
      is_read_q    <= 1'b0;
      in_addr_q    <= 1'b0;
      active_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (pop) begin
        shift_q      <= shift_d;
        bit_count_q  <= bit_count_d;
        phase_high_q <= phase_high_d;
        bytes_left_q <= bytes_left_d;
        is_read_q    <= is_read_d;
        in_addr_q    <= in_addr_d;
        active_q     <= active_d;
        out_valid_q  <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_idle_phase_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> !phase_high_q && !is_read_q)
    else $error("phase or read flag set while idle");

  a_idle_selects_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_word_q.busy_res |-> out_word_q.chip_select_n == CS_IDLE)
    else $error("select low outside a transaction");

  a_req_or_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_word_q.read_valid && out_word_q.data_request))
    else $error("read byte and write request together");

  a_last_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_word_q.last_byte |->
      out_word_q.read_valid || out_word_q.data_request)
    else $error("last byte flag without a byte event");

endmodule

// ----- rtl/spi_register_access_master.sv -----
// Top level of the SPI mode-0 register access master.
//
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+-----------------------
//  in      | input     | in_valid_i/in_stall_o | in_word_i (one tick)
//  out     | output    | out_valid_o/out_stall_i | out_word_o (pin levels)
//  cfg     | input     | APB psel/penable      | device_select at 0x0
//
//  One word in per cycle unless stalled; one result word per input word.
//  Words pass the queue register, then the engine output register.
//  The engine advances one half-bit tick per popped word.
//  Reset idles the engine; the output word register is not reset.
//  out_stall_i holds the output register; the two-entry queue absorbs
//  that and raises in_stall_o only when full.
module spi_register_access_master #(
  parameter int QueueDepth = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  spiram_pkg::in_word_t in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output spiram_pkg::out_word_t out_word_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import spiram_pkg::*;

  cmd_word_t front_cmd;
  cmd_word_t head_cmd;
  logic      full, empty, pop;
  logic      device_select_q;
  logic      reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_DEVICE_SELECT);
  assign prdata  = reg_hit ? {31'b0, device_select_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_select_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      device_select_q <= pwdata[0];
    end
  end

  spiram_front u_front (
    .word_i (in_word_i),
    .cmd_o  (front_cmd)
  );

  assign in_stall_o = full;

  spiram_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_word_i (front_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head_cmd)
  );

  spiram_engine u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .device_select_i (device_select_q),
    .cmd_valid_i     (!empty),
    .cmd_i           (head_cmd),
    .cmd_pop_o       (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_word_o      (out_word_o)
  );

endmodule

// ----- dv/testbench.sv -----
// Testbench for the SPI register access master: queued tick words, predicted pin levels.
`timescale 1ns / 100ps

module testbench;
  import spiram_pkg::*;

  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam logic [2:0]  DEV_SEL_ADDR = {REG_DEVICE_SELECT, 2'b00};
  localparam int          CYCLE_LIMIT = 400_000;
  localparam int          LONG_HOLD   = 240;
  localparam logic [10:0] RX_PAT      = 11'b01100010110;

  typedef enum int {RX_NONE, RX_RANDOM, RX_PATTERN} rx_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_word_t    in_word_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_word_t   out_word_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  spi_register_access_master uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk_i = ~clk_i;

  in_word_t  tick_q[$];
  out_word_t pin_levels_q[$];
  int        ticks_made = 0;
  int        words_seen = 0;
  int        bad_words = 0;
  int        cyc = 0;

  // predictor state
  logic       dev_sel = 1'b0;
  logic [7:0] sh_reg = '0;
  logic [2:0] bit_idx = '0;
  logic       sck_high = 1'b0;
  logic [7:0] bytes_rem = '0;
  logic       rd_mode = 1'b0;
  logic       addr_phase = 1'b0;
  logic       xfer_on = 1'b0;

  // stimulus shaping
  bit       tx_bursty = 1'b0;
  int       burst_left = 0;
  int       gap_left = 0;
  bit       in_hold = 1'b0;
  rx_mode_e rx_mode = RX_NONE;
  bit       hold_go = 1'b0;
  int       hold_left = 0;
  int       rx_cyc = 0;

  function automatic out_word_t spi_tick(in_word_t w);
    out_word_t r;
    r = '0;
    if (!xfer_on) begin
      if ((w.operation == OP_WRITE || w.operation == OP_READ) && w.length != 8'd0) begin
        xfer_on    = 1'b1;
        rd_mode    = (w.operation == OP_READ);
        sh_reg     = {1'b0, w.address} | (rd_mode ? 8'h00 : WRITE_FLAG);
        bit_idx    = '0;
        sck_high   = 1'b0;
        bytes_rem  = w.length;
        addr_phase = 1'b1;
      end
    end else if (!sck_high) begin
      sck_high = 1'b1;
      if (rd_mode && !addr_phase) sh_reg = {sh_reg[6:0], w.miso};
      if (!rd_mode && bit_idx == LAST_BIT && (addr_phase || bytes_rem > 8'd1)) begin
        r.data_request = 1'b1;
        r.last_byte    = addr_phase ? (bytes_rem == 8'd1) : (bytes_rem == 8'd2);
      end
    end else begin
      sck_high = 1'b0;
      if (!(rd_mode && !addr_phase)) sh_reg = {sh_reg[6:0], 1'b0};
      bit_idx = bit_idx + 3'd1;
      if (bit_idx == 3'd0) begin
        if (!addr_phase) begin
          bytes_rem = bytes_rem - 8'd1;
          if (rd_mode) begin
            r.read_valid = 1'b1;
            r.read_data  = sh_reg;
            r.last_byte  = (bytes_rem == 8'd0);
          end
        end
        addr_phase = 1'b0;
        if (bytes_rem == 8'd0) begin
          xfer_on = 1'b0;
          rd_mode = 1'b0;
        end else begin
          sh_reg = rd_mode ? 8'h00 : w.write_data;
        end
      end
    end
    r.chip_select_n = CS_IDLE;
    r.sck           = 1'b0;
    r.mosi          = 1'b1;
    if (xfer_on) begin
      r.chip_select_n = dev_sel ? CS_MODULE1 : CS_MODULE0;
      r.sck           = sck_high;
      if (!(rd_mode && !addr_phase)) r.mosi = sh_reg[7];
    end
    r.busy_res = xfer_on;
    return r;
  endfunction

  task automatic note_bad(string msg);
    bad_words++;
    if (bad_words <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // sender
  always @(posedge clk_i) begin
    in_hold = 1'b0;
    if (rst_ni && in_valid_i) begin
      if (in_stall_o) in_hold = 1'b1;
      else pin_levels_q.push_back(spi_tick(tick_q.pop_front()));
    end
  end

  always @(negedge clk_i) begin
    if (!(in_valid_i && in_hold)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (rst_ni && tick_q.size() != 0) begin
        in_valid_i <= 1'b1;
        in_word_i  <= tick_q[0];
        if (tx_bursty) begin
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = $urandom_range(1, 8);
          end
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (hold_go) begin
      hold_left = LONG_HOLD;
      hold_go   = 1'b0;
    end
    rx_cyc++;
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      case (rx_mode)
        RX_RANDOM:  out_stall_i <= ($urandom_range(0, 9) < 4);
        RX_PATTERN: out_stall_i <= RX_PAT[rx_cyc % 11];
        default:    out_stall_i <= 1'b0;
      endcase
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      words_seen++;
      if (pin_levels_q.size() == 0) begin
        note_bad($sformatf("word %0d unexpected: got %p", words_seen, out_word_o));
      end else begin
        want = pin_levels_q.pop_front();
        if (out_word_o !== want)
          note_bad($sformatf("word %0d: expected %p got %p", words_seen, want, out_word_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cyc++;
    if (cyc > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    dev_sel = data[0];
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[0] !== data[0])
      note_bad($sformatf("readback of 0x%0h: expected %0d got %0d", addr, data[0], prdata[0]));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic push_word(logic [1:0] op, int addr, int len, int wd, int mi);
    in_word_t w;
    w.operation  = op;
    w.address    = addr[6:0];
    w.length     = len[7:0];
    w.write_data = (wd < 0) ? 8'($urandom_range(0, 255)) : wd[7:0];
    w.miso       = (mi < 0) ? 1'($urandom_range(0, 1)) : mi[0];
    tick_q.push_back(w);
    ticks_made++;
  endtask

  // one full transaction: start word plus 16 ticks per byte, address byte included
  task automatic push_xfer(logic [1:0] op, int addr, int len, int wd, int mi, bit end_start);
    int n;
    logic [1:0] top;
    n = 16 * (len + 1);
    push_word(op, addr, len, wd, mi);
    for (int i = 1; i <= n; i++) begin
      top = OP_TICK;
      if ((i == n && end_start) || $urandom_range(0, 24) == 0)
        top = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
      push_word(top, $urandom_range(0, 127), $urandom_range(0, 255), wd, mi);
    end
  endtask

  function automatic int rand_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 2);
    if (r < 99) return $urandom_range(3, 12);
    return $urandom_range(13, 40);
  endfunction

  task automatic fill_random(int n);
    int base;
    int r;
    base = ticks_made;
    while (ticks_made - base < n) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        push_xfer($urandom_range(0, 1) ? OP_WRITE : OP_READ, $urandom_range(0, 127),
                  rand_len(), -1, -1, $urandom_range(0, 3) == 0);
      end else if (r < 90) begin
        push_word($urandom_range(0, 1) ? OP_WRITE : OP_READ, $urandom_range(0, 127), 0, -1, -1);
      end else begin
        repeat ($urandom_range(1, 4))
          push_word($urandom_range(0, 1) ? OP_TICK : OP_UNUSED, $urandom_range(0, 127),
                    $urandom_range(0, 255), -1, -1);
      end
    end
  endtask

  task automatic settle();
    while (tick_q.size() != 0 || pin_levels_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_phase(bit dsel, bit bursty, rx_mode_e rxm);
    cfg_write(DEV_SEL_ADDR, {31'b0, dsel});
    tx_bursty = bursty;
    rx_mode   = rxm;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: ignored commands, extreme fields, busy and end-of-transfer starts
    set_phase(1'b0, 1'b0, RX_NONE);
    push_word(OP_UNUSED, 127, 255, 255, 1);
    push_word(OP_WRITE, 127, 0, 255, 1);
    push_word(OP_READ, 0, 0, 0, 0);
    push_xfer(OP_WRITE, 127, 1, 255, 1, 1'b1);
    push_xfer(OP_READ, 0, 1, 0, 1, 1'b0);
    push_xfer(OP_READ, 85, 2, 255, 0, 1'b1);
    push_xfer(OP_WRITE, 0, 2, 0, 0, 1'b0);
    push_xfer(OP_WRITE, 42, 1, -1, -1, 1'b0);
    settle();

    set_phase(1'b1, 1'b1, RX_RANDOM);
    fill_random(150);
    settle();

    set_phase(1'b0, 1'b1, RX_PATTERN);
    fill_random(150);
    hold_go = 1'b1;
    settle();

    set_phase(1'b1, 1'b0, RX_NONE);
    fill_random(150);
    settle();

    set_phase(1'b0, 1'b1, RX_RANDOM);
    fill_random(150);
    settle();

    // multi-byte write with a start on its final tick, then random traffic
    set_phase(1'b1, 1'b1, RX_PATTERN);
    push_xfer(OP_WRITE, $urandom_range(0, 127), 6, -1, -1, 1'b1);
    fill_random(50);
    settle();

    repeat (10) @(posedge clk_i);
    if (pin_levels_q.size() != 0) note_bad("expected words left over");
    if (bad_words == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
